// ===== hw/rtl/bba_pkg.sv =====
`default_nettype none

package bba_pkg;

   localparam int unsigned MAX_BLOCKS_DEFAULT = 32768;
   localparam int unsigned INDEX_SPAN         = 32768;

   localparam int unsigned MODE_W = 2;
   localparam int unsigned IDX_W  = 15;
   localparam int unsigned CFG_W  = 16;
   localparam int unsigned WORD_W = 64;
   localparam int unsigned BIT_W  = 6;

   localparam logic [CFG_W-1:0] BLOCK_COUNT_RESET = CFG_W'(32768);

   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MARK  = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIND,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      RES_NONE,
      RES_GRANT,
      RES_EXH,
      RES_OOR
   } res_type;

   typedef struct packed {
      logic    clear;
      logic    load;
      logic    read_word;
      logic    commit;
      logic    res_wr;
      res_type res;
      logic    emit;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic top_full;
      logic in_range;
      logic word_ok;
      logic hit_ok;
      logic alloc;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bba_ram.sv =====
`default_nettype none

module bba_ram #(
   parameter int unsigned WIDTH  = 64,
   parameter int unsigned DEPTH  = 512,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bba_ctrl.sv =====
`default_nettype none

module bba_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic [bba_pkg::MODE_W-1:0]       req_mode,
   output logic                             req_stall,
   input  bba_pkg::dp_status_type           status,
   output bba_pkg::dp_cmd_type              cmd
);

   import bba_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.res   = RES_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (req_mode)
                  MODE_ALLOC: begin
                     if (status.top_full) begin
                        cmd.res_wr = 1'b1;
                        cmd.res    = RES_EXH;
                        state_in   = ST_DONE;
                     end else begin
                        state_in = ST_FIND;
                     end
                  end
                  MODE_FREE, MODE_MARK: begin
                     if (status.in_range) begin
                        state_in = ST_UPDATE;
                     end else begin
                        cmd.res_wr = 1'b1;
                        cmd.res    = RES_OOR;
                        state_in   = ST_DONE;
                     end
                  end
                  default: begin
                     cmd.res_wr = 1'b1;
                     cmd.res    = RES_NONE;
                     state_in   = ST_DONE;
                  end
               endcase
            end
         end
         ST_FIND: begin
            if (status.word_ok) begin
               cmd.read_word = 1'b1;
               state_in      = ST_UPDATE;
            end else begin
               // lowest non-full word lies past the end of the map
               cmd.res_wr = 1'b1;
               cmd.res    = RES_EXH;
               state_in   = ST_DONE;
            end
         end
         ST_UPDATE: begin
            cmd.res_wr = 1'b1;
            state_in   = ST_DONE;
            if (status.alloc) begin
               if (status.hit_ok) begin
                  cmd.commit = 1'b1;
                  cmd.res    = RES_GRANT;
               end else begin
                  cmd.res = RES_EXH;
               end
            end else begin
               cmd.commit = 1'b1;
               cmd.res    = RES_NONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/bba_dp.sv =====
`default_nettype none

module bba_dp #(
   parameter int unsigned MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bba_pkg::CFG_W-1:0]     block_count,
   input  logic [bba_pkg::MODE_W-1:0]    req_mode,
   input  logic [bba_pkg::IDX_W-1:0]     req_block_index,
   input  bba_pkg::dp_cmd_type           cmd,
   output bba_pkg::dp_status_type        status,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bba_pkg::IDX_W-1:0]     rsp_granted_index,
   output logic                          rsp_exhausted,
   output logic                          rsp_out_of_range
);

   import bba_pkg::*;

   localparam int unsigned NWORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int unsigned NROWS  = (NWORDS + WORD_W - 1) / WORD_W;
   localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int unsigned RW     = (NROWS > 1) ? $clog2(NROWS) : 1;
   localparam int unsigned WW     = RW + BIT_W;
   localparam int unsigned HW     = WW + BIT_W;
   localparam int unsigned CW     = (HW > CFG_W) ? HW : CFG_W;
   localparam int unsigned XW     = (HW > IDX_W) ? HW : IDX_W;
   localparam int unsigned CAP    = (MAX_BLOCKS < INDEX_SPAN) ? MAX_BLOCKS : INDEX_SPAN;

   function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] value);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!value[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

   logic [MODE_W-1:0] mode_ff,  mode_in;
   logic [RW-1:0]     row_ff,   row_in;
   logic [WW-1:0]     word_ff,  word_in;
   logic [BIT_W-1:0]  bit_ff,   bit_in;
   logic [NROWS-1:0]  top_ff,   top_in;
   logic [AW-1:0]     clr_ff,   clr_in;

   logic [IDX_W-1:0]  res_granted_ff, res_granted_in;
   logic              res_exh_ff,     res_exh_in;
   logic              res_oor_ff,     res_oor_in;

   logic              rsp_valid_ff,     rsp_valid_in;
   logic [IDX_W-1:0]  rsp_granted_ff,   rsp_granted_in;
   logic              rsp_exh_ff,       rsp_exh_in;
   logic              rsp_oor_ff,       rsp_oor_in;

   logic [CFG_W-1:0]  limit;
   logic [XW-1:0]     idx_ext;
   logic [WW-1:0]     idx_word;
   logic [RW-1:0]     idx_row;
   logic [RW-1:0]     top_row;
   logic              req_alloc;
   logic              req_update;
   logic              alloc;

   logic [WORD_W-1:0] mark_rd;
   logic [WORD_W-1:0] word_rd;
   logic [BIT_W-1:0]  mark_lz;
   logic [BIT_W-1:0]  word_lz;
   logic [WW-1:0]     found_word;
   logic [HW-1:0]     hit;
   logic [BIT_W-1:0]  bit_pos;
   logic [WORD_W-1:0] new_word;
   logic [WORD_W-1:0] new_row;

   logic              used_wr_en, used_rd_en;
   logic [AW-1:0]     used_wr_addr, used_rd_addr;
   logic [WORD_W-1:0] used_wr_data;
   logic              mark_wr_en;
   logic [RW-1:0]     mark_wr_addr, mark_rd_addr;
   logic [WORD_W-1:0] mark_wr_data;

   // request decode
   assign limit      = (block_count > CFG_W'(CAP)) ? CFG_W'(CAP) : block_count;
   assign idx_ext    = XW'(req_block_index);
   assign idx_word   = WW'(idx_ext >> BIT_W);
   assign idx_row    = RW'(idx_ext >> (2 * BIT_W));
   assign req_alloc  = (req_mode == MODE_ALLOC);
   assign req_update = (req_mode == MODE_FREE) || (req_mode == MODE_MARK);
   assign alloc      = (mode_ff == MODE_ALLOC);

   always_comb begin
      top_row = '0;
      for (int i = NROWS - 1; i >= 0; i--) begin
         if (!top_ff[i]) begin
            top_row = RW'(i);
         end
      end
   end

   assign mark_lz    = lowest_zero(mark_rd);
   assign word_lz    = lowest_zero(word_rd);
   assign found_word = {row_ff, mark_lz};
   assign hit        = {word_ff, word_lz};
   assign bit_pos    = alloc ? word_lz : bit_ff;

   always_comb begin
      new_word          = word_rd;
      new_word[bit_pos] = (mode_ff != MODE_FREE);
      new_row                         = mark_rd;
      new_row[word_ff[BIT_W-1:0]]     = &new_word;
   end

   assign status.clear_last = (clr_ff == AW'(NWORDS - 1));
   assign status.top_full   = &top_ff;
   assign status.in_range   = CW'(req_block_index) < CW'(limit);
   assign status.word_ok    = {1'b0, found_word} < (WW + 1)'(NWORDS);
   assign status.hit_ok     = CW'(hit) < CW'(limit);
   assign status.alloc      = alloc;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   // used-block words
   assign used_wr_en   = cmd.clear || cmd.commit;
   assign used_wr_addr = cmd.clear ? clr_ff : word_ff[AW-1:0];
   assign used_wr_data = cmd.clear ? '0 : new_word;
   assign used_rd_en   = cmd.read_word || (cmd.load && req_update && status.in_range);
   assign used_rd_addr = cmd.read_word ? found_word[AW-1:0] : idx_word[AW-1:0];

   // full-word summary rows, one bit per used-block word, set when that word is full
   assign mark_wr_en   = (cmd.clear && ({1'b0, clr_ff} < (AW + 1)'(NROWS))) || cmd.commit;
   assign mark_wr_addr = cmd.clear ? clr_ff[RW-1:0] : row_ff;
   assign mark_wr_data = cmd.clear ? '0 : new_row;
   assign mark_rd_addr = req_alloc ? top_row : idx_row;

   bba_ram #(
      .WIDTH  (WORD_W),
      .DEPTH  (NWORDS),
      .ADDR_W (AW)
   ) u_used_ram (
      .clock   (clock),
      .wr_en   (used_wr_en),
      .wr_addr (used_wr_addr),
      .wr_data (used_wr_data),
      .rd_en   (used_rd_en),
      .rd_addr (used_rd_addr),
      .rd_data (word_rd)
   );

   bba_ram #(
      .WIDTH  (WORD_W),
      .DEPTH  (NROWS),
      .ADDR_W (RW)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_wr_en),
      .wr_addr (mark_wr_addr),
      .wr_data (mark_wr_data),
      .rd_en   (cmd.load),
      .rd_addr (mark_rd_addr),
      .rd_data (mark_rd)
   );

   always_comb begin
      mode_in = mode_ff;
      row_in  = row_ff;
      word_in = word_ff;
      bit_in  = bit_ff;
      if (cmd.load) begin
         mode_in = req_mode;
         bit_in  = req_block_index[BIT_W-1:0];
         row_in  = req_alloc ? top_row : idx_row;
         word_in = idx_word;
      end else if (cmd.read_word) begin
         word_in = found_word;
      end
   end

   always_comb begin
      top_in = top_ff;
      clr_in = clr_ff;
      if (cmd.clear) begin
         clr_in = clr_ff + AW'(1);
      end
      if (cmd.commit) begin
         top_in[row_ff] = &new_row;
      end
   end

   always_comb begin
      res_granted_in = res_granted_ff;
      res_exh_in     = res_exh_ff;
      res_oor_in     = res_oor_ff;
      if (cmd.res_wr) begin
         res_granted_in = '0;
         res_exh_in     = 1'b0;
         res_oor_in     = 1'b0;
         unique case (cmd.res)
            RES_NONE:  res_granted_in = '0;
            RES_GRANT: res_granted_in = IDX_W'(hit);
            RES_EXH:   res_exh_in     = 1'b1;
            RES_OOR:   res_oor_in     = 1'b1;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_exh_in     = rsp_exh_ff;
      rsp_oor_in     = rsp_oor_ff;
      priority if (cmd.emit) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = res_granted_ff;
         rsp_exh_in     = res_exh_ff;
         rsp_oor_in     = res_oor_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         top_ff       <= top_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      row_ff         <= row_in;
      word_ff        <= word_in;
      bit_ff         <= bit_in;
      res_granted_ff <= res_granted_in;
      res_exh_ff     <= res_exh_in;
      res_oor_ff     <= res_oor_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_exh_ff     <= rsp_exh_in;
      rsp_oor_ff     <= rsp_oor_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_exhausted     = rsp_exh_ff;
   assign rsp_out_of_range  = rsp_oor_ff;

`ifndef ASSERT_OFF
   a_exh_no_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_exh_ff) |-> (rsp_granted_ff == '0))
      else $error("exhausted result carries a granted index");

   a_single_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_exh_ff && rsp_oor_ff))
      else $error("exhausted and out of range raised together");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten before its transfer");

   a_commit_summary: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (top_ff[$past(row_ff)] == $past(&new_row)))
      else $error("row summary out of step with committed row");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_block_allocator.sv =====
// Request transfer to rsp_valid high: allocate passes FIND, UPDATE and DONE, free and mark-used
// UPDATE and DONE, exhausted-at-summary, out-of-range and unused mode DONE only. One request in
// flight; the next is taken once the result sits in the output register, so allocate's pace is
// set by the summary-row read then word read-modify-write. Synchronous reset: after release the
// bitmap RAM is cleared one word per cycle, MAX_BLOCKS/64 words (512 by default), with req_stall
// high; csr writes are taken throughout.
`default_nettype none

module bitmap_block_allocator #(
   parameter int unsigned MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bba_pkg::CFG_W-1:0]     csr_block_count,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bba_pkg::MODE_W-1:0]    req_mode,
   input  logic [bba_pkg::IDX_W-1:0]     req_block_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bba_pkg::IDX_W-1:0]     rsp_granted_index,
   output logic                          rsp_exhausted,
   output logic                          rsp_out_of_range
);

   import bba_pkg::*;

   logic [CFG_W-1:0] block_count_ff;
   logic [CFG_W-1:0] block_count_in;
   dp_cmd_type       cmd;
   dp_status_type    status;

   assign csr_ready = 1'b1;

   always_comb begin
      block_count_in = block_count_ff;
      if (csr_valid && csr_ready) begin
         block_count_in = csr_block_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= BLOCK_COUNT_RESET;
      end else begin
         block_count_ff <= block_count_in;
      end
   end

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bba_dp #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .block_count       (block_count_ff),
      .req_mode          (req_mode),
      .req_block_index   (req_block_index),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_granted_index (rsp_granted_index),
      .rsp_exhausted     (rsp_exhausted),
      .rsp_out_of_range  (rsp_out_of_range)
   );

endmodule

`default_nettype wire
